@@ rtl/core/cda_pkg.sv @@
`timescale 1ns / 1ps

package cda_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned OFFS_W  = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] LEN_NONE     = 5'd0;

    typedef struct packed {
        logic [YEAR_W-1:0]         start_year;
        logic [MONTH_W-1:0]        start_month;
        logic [DAY_W-1:0]          start_day;
        logic signed [OFFS_W-1:0]  day_offset;
    } t_cda_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic               invalid;
    } t_cda_out;

endpackage

@@ rtl/core/cda_month_len.sv @@
`timescale 1ns / 1ps

module cda_month_len (
    input  logic [cda_pkg::MONTH_W-1:0] i_month,
    input  logic                        i_leap,
    output logic [cda_pkg::DAY_W-1:0]   o_len
);
    import cda_pkg::*;

    always_comb begin
        unique case (i_month) inside
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: begin
                o_len = LEN_LONG;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                o_len = LEN_SHORT;
            end
            MONTH_FEB: begin
                o_len = i_leap ? LEN_FEB_LEAP : LEN_FEB;
            end
            default: begin
                // month code out of range: no day can fit
                o_len = LEN_NONE;
            end
        endcase
    end

endmodule

@@ rtl/core/calendar_date_add_days.sv @@
`timescale 1ns / 1ps

// Gregorian date plus signed day offset. Drive a word on i_word and pulse
// start while busy is low; the word is taken at that edge and busy rises.
// The result appears on o_word for exactly one cycle with o_valid high and
// must be captured then, since the block cannot be stalled. busy falls the
// cycle after the strobe. After acceptance the year modulo 25 is found for
// the leap rule (a reciprocal multiply for the quotient, then the shared
// adder for the remainder), then the date is checked and the offset folded
// in, then one 17-bit adder walks the date one month per cycle, and a
// closing step ends the walk. The walk crosses up to about 1077 month
// boundaries for the largest offsets. An invalid date goes from the check
// straight to the result; a walk that leaves years 1 to 9999 stops at that
// year boundary. With invalid set, the input date is echoed.
module calendar_date_add_days (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cda_pkg::t_cda_in  i_word,
    output logic              o_valid,
    output cda_pkg::t_cda_out o_word
);
    import cda_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QUOT  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // year / 25 as floor(year * 5243 / 2^17), exact for any 14-bit year
    localparam logic [12:0]   RECIP_25  = 13'd5243;
    localparam logic [4:0]    MOD_BASE  = 5'd25;
    localparam logic [4:0]    M25_LAST  = 5'd24;

    logic [2:0]          r_state, n_state;
    t_cda_in             r_in, n_in;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic signed [16:0]  r_day, n_day;
    logic [9:0]          r_quot, n_quot;
    logic [4:0]          r_m25, n_m25;
    logic                r_fwd, n_fwd;
    logic                r_bad, n_bad;

    // shared adder
    logic signed [16:0]  w_op_a, w_op_b, w_sum;
    logic                w_sum_pos;

    // year residue helpers
    logic [26:0]         w_prod;
    logic [14:0]         w_quot25;

    logic                w_leap;
    logic [MONTH_W-1:0]  w_prev_month;
    logic [MONTH_W-1:0]  w_len_month;
    logic [DAY_W-1:0]    w_len;
    logic signed [16:0]  w_len_s;
    logic                w_date_ok;

    // year is divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
    assign w_leap = (r_year[1:0] == 2'b00) && ((r_m25 != 5'd0) || (r_year[3:0] == 4'd0));

    assign w_prev_month = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;

    // backward steps take the length of the month being entered; a step
    // into December of the previous year needs no leap flag
    assign w_len_month = (r_state == ST_WALK && !r_fwd) ? w_prev_month : r_month;

    cda_month_len u_len (
        .i_month (w_len_month),
        .i_leap  (w_leap),
        .o_len   (w_len)
    );

    assign w_len_s  = $signed({12'b0, w_len});
    assign w_prod   = 27'(r_year) * 27'(RECIP_25);
    assign w_quot25 = 15'(r_quot) * 15'(MOD_BASE);

    always_comb begin
        unique case (r_state)
            ST_MOD: begin
                w_op_a = $signed({3'b0, r_year});
                w_op_b = -$signed({2'b0, w_quot25});
            end
            ST_CHECK: begin
                w_op_a = $signed({r_in.day_offset[OFFS_W-1], r_in.day_offset});
                w_op_b = $signed({12'b0, r_in.start_day});
            end
            ST_WALK: begin
                w_op_a = r_day;
                w_op_b = r_fwd ? -w_len_s : w_len_s;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_sum     = w_op_a + w_op_b;
    assign w_sum_pos = !w_sum[16] && (w_sum != 17'sd0);

    // month code and range checks on the captured date; an unknown month
    // gives length zero, so the day check fails with it
    assign w_date_ok = (r_in.start_year >= YEAR_MIN) && (r_in.start_year <= YEAR_MAX) &&
                       (r_in.start_day != 5'd0) && (r_in.start_day <= w_len);

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_quot  = r_quot;
        n_m25   = r_m25;
        n_fwd   = r_fwd;
        n_bad   = r_bad;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_in    = i_word;
                    n_year  = i_word.start_year;
                    n_month = i_word.start_month;
                    n_bad   = 1'b0;
                    n_state = ST_QUOT;
                end
            end
            ST_QUOT: begin
                // hold the quotient of the year by 25
                n_quot  = w_prod[26:17];
                n_state = ST_MOD;
            end
            ST_MOD: begin
                // year minus 25 times the quotient is the residue
                n_m25   = w_sum[4:0];
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!w_date_ok) begin
                    n_bad   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_day   = w_sum;
                    n_fwd   = !r_in.day_offset[OFFS_W-1] && (r_in.day_offset != 16'sd0);
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_fwd) begin
                    // leave the current month while the day still overflows it
                    if (w_sum_pos) begin
                        n_day = w_sum;
                        if (r_month == MONTH_DEC) begin
                            n_month = MONTH_JAN;
                            n_year  = r_year + 14'd1;
                            n_m25   = (r_m25 == M25_LAST) ? 5'd0 : r_m25 + 5'd1;
                            if (r_year == YEAR_MAX) begin
                                n_bad   = 1'b1;
                                n_state = ST_DONE;
                            end
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    // step back into the previous month while the day is below one
                    if (!r_day[16] && (r_day != 17'sd0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_day   = w_sum;
                        n_month = w_prev_month;
                        if (r_month == MONTH_JAN) begin
                            n_year = r_year - 14'd1;
                            n_m25  = (r_m25 == 5'd0) ? M25_LAST : r_m25 - 5'd1;
                            if (r_year == YEAR_MIN) begin
                                n_bad   = 1'b1;
                                n_state = ST_DONE;
                            end
                        end
                    end
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_quot  <= n_quot;
        r_m25   <= n_m25;
        r_fwd   <= n_fwd;
        r_bad   <= n_bad;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

    // echo the input date when flagged
    assign o_word.end_year  = r_bad ? r_in.start_year  : r_year;
    assign o_word.end_month = r_bad ? r_in.start_month : r_month;
    assign o_word.end_day   = r_bad ? r_in.start_day   : r_day[DAY_W-1:0];
    assign o_word.invalid   = r_bad;

    // an accepted word always leads to a busy sequencer
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not start the sequencer");

    // each result is a single-cycle strobe followed by a free block
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe lasted more than one cycle");

    // a clean result is a well-formed date
    a_result_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.invalid) |->
            ((o_word.end_month >= MONTH_JAN) && (o_word.end_month <= MONTH_DEC) &&
             (o_word.end_day != 5'd0) && (o_word.end_year >= YEAR_MIN) &&
             (o_word.end_year <= YEAR_MAX)))
        else $error("valid result is not a well-formed date");

    // the year residue stays below 25 throughout the walk
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_m25 <= M25_LAST))
        else $error("year residue out of range");

endmodule
